// File: hdl/acc_id_pkg.sv
// Shared types, constants and the range lookup for the accessory ID classifier.
package acc_id_pkg;

    localparam int NUM_CLASSES_DEF = 12;
    localparam int ADC_BITS_DEF    = 10;

    localparam int CLASS_W   = 4;
    localparam int READ_W    = 8;
    localparam int MATCH_W   = 4;
    localparam int ATTEMPT_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;
    localparam int TABLE_LEN = 12;

    localparam logic [CLASS_W-1:0]   UNKNOWN_CLASS = 4'hF;
    localparam logic [MATCH_W-1:0]   MATCH_MAX     = 4'hF;
    localparam logic [ATTEMPT_W-1:0] ATTEMPT_MAX   = 8'hFF;

    localparam logic [MATCH_W-1:0]   REQ_MATCHES_RST   = 4'd3;
    localparam logic [ATTEMPT_W-1:0] ATTEMPT_LIMIT_RST = 8'd100;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_START  = 2'd1,
        CMD_FORGET = 2'd2
    } t_command;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REQ_MATCHES   = 2'd0,
        REG_ATTEMPT_LIMIT = 2'd1
    } t_cfg_reg;

    typedef logic [READ_W-1:0] t_range_tops [TABLE_LEN];

    localparam t_range_tops RANGE_TOP = '{
        8'h0E, 8'h21, 8'h34, 8'h46, 8'h5C, 8'h73,
        8'h89, 8'hA0, 8'hBD, 8'hD9, 8'hEE, 8'hFF
    };

    // First range whose top is not below the reading; last class if none.
    function automatic logic [CLASS_W-1:0] classify(
        input logic [READ_W-1:0]  reading,
        input logic [CLASS_W-1:0] num_classes
    );
        logic [CLASS_W-1:0] cls;
        cls = num_classes - 4'd1;
        for (int i = TABLE_LEN - 1; i >= 0; i--) begin
            if ((CLASS_W'(i) < num_classes) && (reading <= RANGE_TOP[i])) begin
                cls = CLASS_W'(i);
            end
        end
        return cls;
    endfunction

endpackage

// File: hdl/accessory_id_adc_classifier_core.sv
// Accessory ID classifier: run control, reading debounce and range lookup.
//
// Identifies an accessory from its resistor-divider ADC reading. A start word
// opens a detection run; each sample word inside a run is one attempt. An
// inactive detect pin ends the run as not connected (class NUM_CLASSES-1); a
// failed ADC read just uses up the attempt; a good read keeps the top 8 ADC
// bits and counts equal readings in a row. Once required_matches equal
// readings are seen, the value is looked up in twelve fixed ranges and the
// run ends with that class. A run that uses attempt_limit attempts without a
// stable value ends as not connected with the unstable flag set. Each end of
// a run emits one result word with the class and a flag saying whether it
// differs from the last reported class; a forget word makes the last class
// unknown. Start, forget and ignored words give no result. Timing: one word
// is taken every cycle; the result appears in the output register, the only
// stage, in the cycle after acceptance. Input ready drops only while a result
// waits in that register and the sink holds off. Configuration writes are
// always taken and must only happen while the block is idle.
module accessory_id_adc_classifier_core
    import acc_id_pkg::*;
#(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF,
    parameter int ADC_BITS    = ADC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    // input word channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_command,
    input  logic                 i_pin_active,
    input  logic                 i_read_ok,
    input  logic [ADC_BITS-1:0]  i_adc_value,
    // result word channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [CLASS_W-1:0]   o_accessory_class,
    output logic                 o_changed,
    output logic                 o_unstable
);

    localparam logic [CLASS_W-1:0] NC_CLASS = CLASS_W'(NUM_CLASSES - 1);
    localparam logic [CLASS_W-1:0] NC_COUNT = CLASS_W'(NUM_CLASSES);

    // configuration registers
    logic [MATCH_W-1:0]   r_req_matches;
    logic [ATTEMPT_W-1:0] r_attempt_limit;

    // run state
    logic                 r_run_active,    n_run_active;
    logic [ATTEMPT_W-1:0] r_attempts,      n_attempts;
    logic [MATCH_W-1:0]   r_match_count,   n_match_count;
    logic [READ_W-1:0]    r_prev_reading,  n_prev_reading;
    logic                 r_prev_valid,    n_prev_valid;
    logic [CLASS_W-1:0]   r_last_class,    n_last_class;

    // result register
    logic                 r_out_valid,     n_out_valid;
    logic [CLASS_W-1:0]   r_out_class,     n_out_class;
    logic                 r_out_changed,   n_out_changed;
    logic                 r_out_unstable,  n_out_unstable;

    logic                 in_accept;
    logic [READ_W-1:0]    reading;
    logic [ATTEMPT_W-1:0] attempts_inc;
    logic [MATCH_W-1:0]   match_base;
    logic [MATCH_W-1:0]   match_inc;
    logic                 finish;
    logic [CLASS_W-1:0]   finish_class;
    logic                 finish_unstable;

    // Output register frees up when empty or being drained this cycle.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign reading      = i_adc_value[ADC_BITS-1 -: READ_W];
    assign attempts_inc = (r_attempts == ATTEMPT_MAX) ? r_attempts : r_attempts + 8'd1;
    // A new or different reading restarts the run of equal values.
    assign match_base   = (!r_prev_valid || (reading != r_prev_reading)) ? '0 : r_match_count;
    assign match_inc    = (match_base == MATCH_MAX) ? match_base : match_base + 4'd1;

    always_comb begin
        n_run_active    = r_run_active;
        n_attempts      = r_attempts;
        n_match_count   = r_match_count;
        n_prev_reading  = r_prev_reading;
        n_prev_valid    = r_prev_valid;
        n_last_class    = r_last_class;
        finish          = 1'b0;
        finish_class    = NC_CLASS;
        finish_unstable = 1'b0;

        if (in_accept) begin
            case (i_command)
                CMD_START: begin
                    n_run_active   = 1'b1;
                    n_attempts     = '0;
                    n_match_count  = '0;
                    n_prev_reading = '0;
                    n_prev_valid   = 1'b0;
                end
                CMD_FORGET: begin
                    n_last_class = UNKNOWN_CLASS;
                end
                CMD_SAMPLE: begin
                    if (r_run_active) begin
                        n_attempts = attempts_inc;
                        if (!i_pin_active) begin
                            finish = 1'b1;
                        end else begin
                            if (i_read_ok) begin
                                n_match_count  = match_inc;
                                n_prev_reading = reading;
                                n_prev_valid   = 1'b1;
                            end
                            // stable value wins over the attempt limit
                            if (i_read_ok && (match_inc >= r_req_matches)) begin
                                finish       = 1'b1;
                                finish_class = classify(reading, NC_COUNT);
                            end else if (attempts_inc >= r_attempt_limit) begin
                                finish          = 1'b1;
                                finish_unstable = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    // unused command code: ignored
                end
            endcase
            if (finish) begin
                n_run_active = 1'b0;
                n_last_class = finish_class;
            end
        end
    end

    always_comb begin
        n_out_valid    = r_out_valid && !i_out_ready;
        n_out_class    = r_out_class;
        n_out_changed  = r_out_changed;
        n_out_unstable = r_out_unstable;
        if (in_accept) begin
            n_out_valid = finish;
            if (finish) begin
                n_out_class    = finish_class;
                n_out_changed  = (finish_class != r_last_class);
                n_out_unstable = finish_unstable;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_matches   <= REQ_MATCHES_RST;
            r_attempt_limit <= ATTEMPT_LIMIT_RST;
            r_run_active    <= 1'b0;
            r_attempts      <= '0;
            r_match_count   <= '0;
            r_prev_reading  <= '0;
            r_prev_valid    <= 1'b0;
            r_last_class    <= UNKNOWN_CLASS;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_REQ_MATCHES:   r_req_matches   <= i_cfg_data[MATCH_W-1:0];
                    REG_ATTEMPT_LIMIT: r_attempt_limit <= i_cfg_data[ATTEMPT_W-1:0];
                    default: begin
                        // write beyond the register list: dropped
                    end
                endcase
            end
            r_run_active   <= n_run_active;
            r_attempts     <= n_attempts;
            r_match_count  <= n_match_count;
            r_prev_reading <= n_prev_reading;
            r_prev_valid   <= n_prev_valid;
            r_last_class   <= n_last_class;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_class    <= n_out_class;
        r_out_changed  <= n_out_changed;
        r_out_unstable <= n_out_unstable;
    end

    assign o_out_valid       = r_out_valid;
    assign o_accessory_class = r_out_class;
    assign o_changed         = r_out_changed;
    assign o_unstable        = r_out_unstable;

endmodule

// File: hdl/acc_id_checker.sv
// Port-level checks for the accessory ID classifier, bound to the top level.
module acc_id_checker
    import acc_id_pkg::*;
#(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic [1:0]         i_command,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [CLASS_W-1:0] o_accessory_class,
    input logic               o_changed,
    input logic               o_unstable
);

    localparam logic [CLASS_W-1:0] NC_CLASS = CLASS_W'(NUM_CLASSES - 1);

    // result word held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_accessory_class) && $stable(o_changed) && $stable(o_unstable))
        else $error("result word changed while stalled");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_accessory_class <= NC_CLASS)
        else $error("class outside range table");

    a_unstable_nc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_unstable |-> o_accessory_class == NC_CLASS)
        else $error("unstable result without not-connected class");

    // only a sample word can end a run
    a_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_command != CMD_SAMPLE) |=> !o_out_valid)
        else $error("result from a non-sample word");

endmodule

bind accessory_id_adc_classifier_core acc_id_checker #(
    .NUM_CLASSES(NUM_CLASSES)
) u_acc_id_checker (.*);
